### sv/msbc_pkg.sv
// Shared widths, codes and thresholds for the modulation select and block count block.
package msbc_pkg;

  // Input field widths
  localparam int SYM_GRP_W = 4;
  localparam int BITMAP_W  = 16;
  localparam int EFF_W     = 8;
  localparam int BYTES_W   = 16;

  // Stream packing
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 1;

  // Output field widths
  localparam int FMT_W    = 3;
  localparam int BLOCKS_W = 8;

  // Configuration registers
  localparam int CARRIERS_W = 8;
  localparam int CTRL_W     = 12;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic            REG_CARRIERS   = 1'b0;
  localparam logic            REG_CONTROL    = 1'b1;
  localparam logic [CARRIERS_W-1:0] CARRIERS_RESET = 8'd24;
  localparam logic [CTRL_W-1:0]     CONTROL_RESET  = 12'd0;

  // Default number of frequency groups that count
  localparam int FREQ_GROUPS_DEF = 16;

  // Coding formats
  localparam logic [FMT_W-1:0] FMT_SS_QPSK  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_SS_16QAM = 3'd1;
  localparam logic [FMT_W-1:0] FMT_SS_64QAM = 3'd2;
  localparam logic [FMT_W-1:0] FMT_DS_QPSK  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_DS_16QAM = 3'd4;
  localparam logic [FMT_W-1:0] FMT_DS_64QAM = 3'd5;

  // Efficiency thresholds
  localparam logic [EFF_W-1:0] SS_16QAM_MIN = 8'd5;
  localparam logic [EFF_W-1:0] SS_64QAM_MIN = 8'd26;
  localparam logic [EFF_W-1:0] SS_EFF_MAX   = 8'd46;
  localparam logic [EFF_W-1:0] DS_EFF_MIN   = 8'd5;
  localparam logic [EFF_W-1:0] DS_16QAM_MIN = 8'd26;
  localparam logic [EFF_W-1:0] DS_64QAM_MIN = 8'd49;
  localparam logic [EFF_W-1:0] DS_EFF_MAX   = 8'd107;

  // Efficiency offset (sixteenths of 1 bps/Hz) and block overhead
  localparam logic [EFF_W:0]     EFF_OFFSET     = 9'd16;
  localparam logic [BYTES_W:0]   BLOCK_OVERHEAD = 17'd4;
  // A block is bytes*8 bits and the efficiency is in sixteenths: 8*16 = 2**7
  localparam int DEN_SHIFT = 7;

endpackage

### sv/modulation_select_and_block_count.sv
// Top level: modulation format select and transport block count pipeline.
//
//  Channel  Dir  Accepted on       Carries
//  s_axis   in   tvalid & tready   one grant request (fields listed at the ports)
//  m_axis   out  tvalid & tready   status, coding_format, num_blocks
//  apb      in   psel & penable    carriers_per_group at 0x0, control_bits at 0x4
//
//  One transaction enters per cycle while s_axis_tready is high; its result is registered through
//  five arithmetic stages (format select and popcount, groups times carriers, times symbols
//  less control bits, efficiency multiply, saturation check) and four restoring division
//  stages that retire two quotient bits each.
//  Reset (rst, synchronous) clears all stage valid bits and loads the register reset values.
//  A stall on m_axis holds each stage whose successor is full; s_axis_tready stays high
//  while any bubble remains.
module modulation_select_and_block_count
  import msbc_pkg::*;
#(
  parameter int FREQ_GROUPS = FREQ_GROUPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] symbol_groups, [19:4] group_bitmap, [27:20] target_efficiency,
  // [43:28] block_bytes, [47:44] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] has_control, [1] dual_stream
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] coding_format, [10:3] num_blocks, [15:11] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] status
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Width chain of the capacity arithmetic
  localparam int CNT_W   = $clog2(FREQ_GROUPS + 1);
  localparam int SYM_W   = SYM_GRP_W + 2;
  localparam int PROD_W  = CNT_W + CARRIERS_W;
  localparam int RAW_W   = PROD_W + SYM_W;
  localparam int EFF9_W  = EFF_W + 1;
  localparam int NUM_W   = RAW_W + EFF9_W;
  localparam int N_W     = NUM_W - DEN_SHIFT;
  localparam int DEN_W   = BYTES_W + 1;
  localparam int LIM_W   = DEN_W + BLOCKS_W;
  localparam int CMP_W   = ((N_W > LIM_W) ? N_W : LIM_W) + 1;
  localparam int DIV_STG = BLOCKS_W / 2;
  localparam int NS      = 5 + DIV_STG;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CARRIERS_W-1:0] carriers_per_group;
  logic [CTRL_W-1:0]     control_bits;
  logic                  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      carriers_per_group <= CARRIERS_RESET;
      control_bits       <= CONTROL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_CARRIERS: carriers_per_group <= pwdata[CARRIERS_W-1:0];
        REG_CONTROL:  control_bits       <= pwdata[CTRL_W-1:0];
        default:      carriers_per_group <= carriers_per_group;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CARRIERS: prdata = {{(APB_DATA_W-CARRIERS_W){1'b0}}, carriers_per_group};
      REG_CONTROL:  prdata = {{(APB_DATA_W-CTRL_W){1'b0}}, control_bits};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage takes new data when it is empty or its successor
  // takes its content this cycle.
  // ---------------------------------------------------------------------------
  logic [NS:1]   vld;
  logic [NS+1:1] rdy;

  always_comb begin
    rdy[NS+1] = m_axis_tready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= s_axis_tvalid;
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Field unpacking
  // ---------------------------------------------------------------------------
  logic                 in_has_ctrl;
  logic                 in_dual;
  logic [SYM_GRP_W-1:0] in_sym_grp;
  logic [BITMAP_W-1:0]  in_bitmap;
  logic [EFF_W-1:0]     in_eff;
  logic [BYTES_W-1:0]   in_bytes;

  assign in_has_ctrl = s_axis_tuser[0];
  assign in_dual     = s_axis_tuser[1];
  assign in_sym_grp  = s_axis_tdata[3:0];
  assign in_bitmap   = s_axis_tdata[19:4];
  assign in_eff      = s_axis_tdata[27:20];
  assign in_bytes    = s_axis_tdata[43:28];

  // ---------------------------------------------------------------------------
  // Stage 1: format select, popcount, control bit select, block size
  // ---------------------------------------------------------------------------
  logic [FMT_W-1:0] fmt_sel;
  logic             bad_sel;
  logic [CNT_W-1:0] cnt_sel;

  always_comb begin
    bad_sel = 1'b0;
    fmt_sel = FMT_SS_QPSK;
    if (in_dual) begin
      if (in_eff < DS_EFF_MIN || in_eff > DS_EFF_MAX) bad_sel = 1'b1;
      else if (in_eff < DS_16QAM_MIN) fmt_sel = FMT_DS_QPSK;
      else if (in_eff < DS_64QAM_MIN) fmt_sel = FMT_DS_16QAM;
      else                            fmt_sel = FMT_DS_64QAM;
    end else begin
      if (in_eff < SS_16QAM_MIN)       fmt_sel = FMT_SS_QPSK;
      else if (in_eff < SS_64QAM_MIN)  fmt_sel = FMT_SS_16QAM;
      else if (in_eff <= SS_EFF_MAX)   fmt_sel = FMT_SS_64QAM;
      else                             bad_sel = 1'b1;
    end
  end

  // Only the low FREQ_GROUPS bitmap bits are allocated groups
  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < FREQ_GROUPS; i++) begin
      cnt_sel = cnt_sel + CNT_W'(in_bitmap[i]);
    end
  end

  logic [CNT_W-1:0]  s1_cnt;
  logic [SYM_W-1:0]  s1_sym;
  logic [FMT_W-1:0]  s1_fmt;
  logic              s1_bad;
  logic [EFF9_W-1:0] s1_eff9;
  logic [CTRL_W-1:0] s1_ctrl;
  logic [DEN_W-1:0]  s1_den;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_cnt  <= cnt_sel;
      s1_sym  <= {in_sym_grp, 2'b00};
      s1_fmt  <= fmt_sel;
      s1_bad  <= bad_sel;
      s1_eff9 <= EFF_OFFSET + {1'b0, in_eff};
      s1_ctrl <= in_has_ctrl ? control_bits : '0;
      s1_den  <= {1'b0, in_bytes} + BLOCK_OVERHEAD;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: groups times carriers
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] s2_prod;
  logic [SYM_W-1:0]  s2_sym;
  logic [FMT_W-1:0]  s2_fmt;
  logic              s2_bad;
  logic [EFF9_W-1:0] s2_eff9;
  logic [CTRL_W-1:0] s2_ctrl;
  logic [DEN_W-1:0]  s2_den;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_prod <= PROD_W'(s1_cnt) * PROD_W'(carriers_per_group);
      s2_sym  <= s1_sym;
      s2_fmt  <= s1_fmt;
      s2_bad  <= s1_bad;
      s2_eff9 <= s1_eff9;
      s2_ctrl <= s1_ctrl;
      s2_den  <= s1_den;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: times symbols, minus control bits, clamp at zero
  // ---------------------------------------------------------------------------
  logic [RAW_W-1:0] raw_full;
  logic [RAW_W-1:0] ctrl_ext;

  assign raw_full = RAW_W'(s2_prod) * RAW_W'(s2_sym);
  assign ctrl_ext = RAW_W'(s2_ctrl);

  logic [RAW_W-1:0]  s3_raw;
  logic [FMT_W-1:0]  s3_fmt;
  logic              s3_bad;
  logic [EFF9_W-1:0] s3_eff9;
  logic [DEN_W-1:0]  s3_den;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_raw  <= (raw_full > ctrl_ext) ? raw_full - ctrl_ext : '0;
      s3_fmt  <= s2_fmt;
      s3_bad  <= s2_bad;
      s3_eff9 <= s2_eff9;
      s3_den  <= s2_den;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: scale by efficiency (bits per format cancels in the ratio)
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] s4_num;
  logic [FMT_W-1:0] s4_fmt;
  logic             s4_bad;
  logic [DEN_W-1:0] s4_den;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_num <= NUM_W'(s3_raw) * NUM_W'(s3_eff9);
      s4_fmt <= s3_fmt;
      s4_bad <= s3_bad;
      s4_den <= s3_den;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: drop the power-of-two part of the divisor, check saturation
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] n_ext;
  logic [CMP_W-1:0] lim_ext;

  assign n_ext   = CMP_W'(s4_num[NUM_W-1:DEN_SHIFT]);
  assign lim_ext = CMP_W'({s4_den, {BLOCKS_W{1'b0}}});

  logic [CMP_W-1:0]    div_rem [0:DIV_STG];
  logic [BLOCKS_W-1:0] div_q   [0:DIV_STG];
  logic [DEN_W-1:0]    div_den [0:DIV_STG];
  logic                div_sat [0:DIV_STG];
  logic [FMT_W-1:0]    div_fmt [0:DIV_STG];
  logic                div_bad [0:DIV_STG];

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      div_rem[0] <= n_ext;
      div_q[0]   <= '0;
      div_den[0] <= s4_den;
      div_sat[0] <= (n_ext >= lim_ext);
      div_fmt[0] <= s4_bad ? FMT_SS_QPSK : s4_fmt;
      div_bad[0] <= s4_bad;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 6..9: restoring division, two quotient bits per stage
  // ---------------------------------------------------------------------------
  for (genvar j = 1; j <= DIV_STG; j++) begin : g_div
    localparam int BIT_HI = BLOCKS_W + 1 - 2 * j;

    logic [CMP_W-1:0]    rem_a;
    logic [CMP_W-1:0]    rem_b;
    logic [CMP_W-1:0]    dsh_hi;
    logic [CMP_W-1:0]    dsh_lo;
    logic [BLOCKS_W-1:0] q_upd;

    always_comb begin
      dsh_hi = CMP_W'(div_den[j-1]) << BIT_HI;
      dsh_lo = CMP_W'(div_den[j-1]) << (BIT_HI - 1);
      q_upd  = div_q[j-1];
      rem_a  = div_rem[j-1];
      if (rem_a >= dsh_hi) begin
        rem_a         = rem_a - dsh_hi;
        q_upd[BIT_HI] = 1'b1;
      end
      rem_b = rem_a;
      if (rem_b >= dsh_lo) begin
        rem_b           = rem_b - dsh_lo;
        q_upd[BIT_HI-1] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[5+j]) begin
        div_rem[j] <= rem_b;
        div_q[j]   <= q_upd;
        div_den[j] <= div_den[j-1];
        div_sat[j] <= div_sat[j-1];
        div_fmt[j] <= div_fmt[j-1];
        div_bad[j] <= div_bad[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result: zero on an illegal efficiency, saturate the block count
  // ---------------------------------------------------------------------------
  logic [BLOCKS_W-1:0] blocks_out;

  assign blocks_out = div_bad[DIV_STG] ? '0 :
                      div_sat[DIV_STG] ? {BLOCKS_W{1'b1}} : div_q[DIV_STG];

  assign m_axis_tdata = {{(OUT_DATA_W-FMT_W-BLOCKS_W){1'b0}}, blocks_out, div_fmt[DIV_STG]};
  assign m_axis_tuser = div_bad[DIV_STG];

endmodule

### test/tb_top.sv
// Testbench for modulation_select_and_block_count: directed table and random grants.
`timescale 1ns / 1ps

module tb_top;
  import msbc_pkg::*;

  // Cycles without any transaction before the run is declared hung. The
  // slowest legal gap is a drain plus a register write or a random stall
  // run, so this is many times over.
  localparam int QUIET_LIMIT = 2000;
  // Pipeline depth is nine; give the tail a little extra.
  localparam int TAIL_CYCLES = 20;
  localparam int SEG_ITEMS   = 125;
  localparam int SEGMENTS    = 6;

  // One grant request, as the block sees it.
  typedef struct packed {
    bit                 has_ctl;
    bit [SYM_GRP_W-1:0] sym_groups;
    bit [BITMAP_W-1:0]  bitmap;
    bit [EFF_W-1:0]     eff;
    bit                 dual;
    bit [BYTES_W-1:0]   bytes;
  } req_t;

  // One grant outcome: status, coding format, transport block count.
  typedef struct packed {
    bit                status;
    bit [FMT_W-1:0]    fmt;
    bit [BLOCKS_W-1:0] blocks;
  } grant_t;

  // Directed row: register setting, request, and an optional typed outcome.
  typedef struct packed {
    bit [CARRIERS_W-1:0] carriers;
    bit [CTRL_W-1:0]     control;
    req_t                req;
    bit                  typed;
    grant_t              want;
  } row_t;

  localparam int DIR_ROWS = 23;

  // Rows grouped by register setting so the block is reconfigured only a few
  // times. Typed outcomes are the ones that are obvious by inspection:
  // illegal efficiencies, zero capacity and saturation.
  row_t dir_tab [0:DIR_ROWS-1] = '{
    // reset setting: 24 carriers, no control bits
    '{24, 0, '{0, 0, 16'h0000, 0, 0, 0}, 1, '{0, FMT_SS_QPSK, 0}},
    '{24, 0, '{1, 15, 16'hffff, 255, 0, 65535}, 1, '{1, '0, 0}},
    '{24, 0, '{0, 7, 16'h00ff, 47, 0, 100}, 1, '{1, '0, 0}},
    '{24, 0, '{1, 15, 16'hffff, 46, 0, 65535}, 0, '0},
    '{24, 0, '{0, 8, 16'h0f0f, 4, 0, 200}, 0, '0},
    '{24, 0, '{0, 8, 16'h0f0f, 5, 0, 200}, 0, '0},
    '{24, 0, '{0, 3, 16'h5555, 25, 0, 20}, 0, '0},
    '{24, 0, '{0, 3, 16'haaaa, 26, 0, 20}, 0, '0},
    '{24, 0, '{0, 5, 16'h0ff0, 4, 1, 50}, 1, '{1, '0, 0}},
    '{24, 0, '{0, 5, 16'h0ff0, 108, 1, 50}, 1, '{1, '0, 0}},
    '{24, 0, '{0, 9, 16'h1234, 5, 1, 300}, 0, '0},
    '{24, 0, '{0, 9, 16'h8421, 25, 1, 300}, 0, '0},
    '{24, 0, '{0, 10, 16'hf00f, 26, 1, 1000}, 0, '0},
    '{24, 0, '{0, 10, 16'hf00f, 48, 1, 1000}, 0, '0},
    '{24, 0, '{0, 12, 16'h7ffe, 49, 1, 4096}, 0, '0},
    '{24, 0, '{0, 15, 16'hffff, 107, 1, 0}, 1, '{0, FMT_DS_64QAM, 255}},
    // one carrier, maximum control bits: capacity clamps when present
    '{1, 4095, '{1, 15, 16'hffff, 30, 0, 0}, 1, '{0, FMT_SS_64QAM, 0}},
    '{1, 4095, '{0, 15, 16'hffff, 30, 0, 0}, 0, '0},
    // zero carriers is out of range but gives zero capacity
    '{0, 4095, '{0, 15, 16'hffff, 100, 1, 0}, 1, '{0, FMT_DS_64QAM, 0}},
    // maximum carriers: saturation, and zero symbols
    '{255, 0, '{0, 15, 16'hffff, 46, 0, 0}, 1, '{0, FMT_SS_64QAM, 255}},
    '{255, 0, '{1, 0, 16'hffff, 46, 0, 0}, 1, '{0, FMT_SS_64QAM, 0}},
    // control bits exactly equal to the raw capacity, then half of it
    '{1, 4, '{1, 1, 16'h0001, 10, 0, 0}, 1, '{0, FMT_SS_16QAM, 0}},
    '{1, 4, '{1, 2, 16'h8000, 60, 1, 0}, 0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [3:0] symbol_groups, [19:4] group_bitmap, [27:20] target_efficiency,
  // [43:28] block_bytes, [47:44] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [0] has_control, [1] dual_stream
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [2:0] coding_format, [10:3] num_blocks, [15:11] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [0] status
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copies of the two registers, as the block should hold them.
  bit [CARRIERS_W-1:0] cfg_carriers = CARRIERS_RESET;
  bit [CTRL_W-1:0]     cfg_control  = CONTROL_RESET;

  // Outcomes of accepted requests, oldest first.
  grant_t pending_grants [$];
  int     errors = 0;
  int     quiet_cycles = 0;
  // Idle percentages for the request and result sides.
  int     req_idle_pct = 17;
  int     rsp_idle_pct = 47;

  modulation_select_and_block_count DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  // Work out the grant outcome for one request under the current registers.
  function automatic grant_t grant_outcome(req_t r);
    grant_t            g;
    bit                bad;
    bit [FMT_W-1:0]    fmt;
    int unsigned       bpf;
    longint unsigned   raw, ctl, cap, num, den, blocks;
    bad = 1'b0;
    fmt = FMT_SS_QPSK;
    // Pick the format from the efficiency thresholds of the stream mode.
    if (r.dual) begin
      if (r.eff < DS_EFF_MIN || r.eff > DS_EFF_MAX) bad = 1'b1;
      else if (r.eff < DS_16QAM_MIN) fmt = FMT_DS_QPSK;
      else if (r.eff < DS_64QAM_MIN) fmt = FMT_DS_16QAM;
      else fmt = FMT_DS_64QAM;
    end else begin
      if (r.eff < SS_16QAM_MIN) fmt = FMT_SS_QPSK;
      else if (r.eff < SS_64QAM_MIN) fmt = FMT_SS_16QAM;
      else if (r.eff <= SS_EFF_MAX) fmt = FMT_SS_64QAM;
      else bad = 1'b1;
    end
    if (bad) begin
      g = '{1'b1, '0, '0};
      return g;
    end
    case (fmt)
      FMT_SS_QPSK:               bpf = 2;
      FMT_SS_16QAM, FMT_DS_QPSK: bpf = 4;
      FMT_SS_64QAM:              bpf = 6;
      FMT_DS_16QAM:              bpf = 8;
      default:                   bpf = 12;
    endcase
    // Raw resource elements, less control bits, clamped at zero.
    raw = $countones(r.bitmap);
    raw = raw * cfg_carriers * (4 * r.sym_groups);
    ctl = r.has_ctl ? cfg_control : 0;
    cap = (raw > ctl) ? (raw - ctl) * bpf : 0;
    num = (EFF_OFFSET + r.eff) * cap;
    den = (r.bytes + BLOCK_OVERHEAD) * 8 * bpf * 16;
    blocks = num / den;
    g.status = 1'b0;
    g.fmt    = fmt;
    g.blocks = (blocks > 255) ? 8'd255 : blocks[BLOCKS_W-1:0];
    return g;
  endfunction

  // Random request: mostly legal efficiencies with small blocks so counts
  // spread over the whole range, the rest unrestricted.
  function automatic req_t random_req();
    req_t r;
    r.has_ctl    = 1'($urandom_range(1));
    r.sym_groups = SYM_GRP_W'($urandom_range(15));
    r.dual       = 1'($urandom_range(1));
    if ($urandom_range(99) < 20) r.bitmap = 16'h1 << $urandom_range(15);
    else r.bitmap = BITMAP_W'($urandom_range(16'hffff));
    if ($urandom_range(99) < 80) r.eff = r.dual ? EFF_W'($urandom_range(DS_EFF_MAX, DS_EFF_MIN))
                                                : EFF_W'($urandom_range(SS_EFF_MAX, 0));
    else r.eff = EFF_W'($urandom_range(255));
    if ($urandom_range(99) < 85) r.bytes = BYTES_W'($urandom_range(600));
    else r.bytes = BYTES_W'($urandom_range(16'hffff));
    return r;
  endfunction

  // Print one mismatch line and count it.
  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Hold until every accepted request has produced its result.
  task automatic settle();
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic reg_write(input logic idx, input bit [APB_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CARRIERS) cfg_carriers = val[CARRIERS_W-1:0];
    else cfg_control = val[CTRL_W-1:0];
  endtask

  // Move to a new register setting: drop valid, drain, write what changed.
  task automatic load_config(input bit [CARRIERS_W-1:0] carr, input bit [CTRL_W-1:0] ctl);
    if (carr != cfg_carriers || ctl != cfg_control) begin
      s_axis_tvalid <= 1'b0;
      settle();
      if (carr != cfg_carriers) reg_write(REG_CARRIERS, carr);
      if (ctl != cfg_control) reg_write(REG_CONTROL, ctl);
    end
  endtask

  // Offer one request, with random idle cycles ahead of it, and record its
  // outcome once the transaction is accepted.
  task automatic send_req(input req_t r, input bit typed, input grant_t typed_want);
    grant_t want;
    want = typed ? typed_want : grant_outcome(r);
    while ($urandom_range(99) < req_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, r.bytes, r.eff, r.bitmap, r.sym_groups};
    s_axis_tuser  <= {r.dual, r.has_ctl};
    do @(posedge clk); while (!s_axis_tready);
    pending_grants.push_back(want);
  endtask

  // Result side back-pressure.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  // Compare each result transaction with the oldest outcome, field by field.
  always @(posedge clk) begin
    grant_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_grants.size() == 0) begin
        report($sformatf("result with nothing pending: tdata %h tuser %h",
                         m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_grants.pop_front();
        if (m_axis_tuser[0] !== want.status)
          report($sformatf("status got %b want %b", m_axis_tuser[0], want.status));
        if (m_axis_tdata[2:0] !== want.fmt)
          report($sformatf("coding_format got %0d want %0d", m_axis_tdata[2:0], want.fmt));
        if (m_axis_tdata[10:3] !== want.blocks)
          report($sformatf("num_blocks got %0d want %0d", m_axis_tdata[10:3], want.blocks));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("modulation_select_and_block_count test failed");
      $finish;
    end
  end

  initial begin
    bit [CARRIERS_W-1:0] carr;
    bit [CTRL_W-1:0]     ctl;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table: thresholds, illegal efficiencies, clamping, saturation.
    for (int i = 0; i < DIR_ROWS; i++) begin
      load_config(dir_tab[i].carriers, dir_tab[i].control);
      send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random segments, each under its own register setting. The first two
    // idle mostly on the result side, the next two mostly on the request
    // side, the last two not at all.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin carr = 255; ctl = 0;    end
        1: begin carr = 1;   ctl = 4095; end
        3: begin carr = 128; ctl = 600;  end
        5: begin carr = 24;  ctl = 0;    end
        default: begin
          carr = CARRIERS_W'($urandom_range(255, 1));
          ctl  = CTRL_W'($urandom_range(4095));
        end
      endcase
      load_config(carr, ctl);
      req_idle_pct = (seg < 2) ? 17 : (seg < 4) ? 47 : 0;
      rsp_idle_pct = (seg < 2) ? 47 : (seg < 4) ? 17 : 0;
      for (int n = 0; n < SEG_ITEMS; n++) send_req(random_req(), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_grants.size() == 0)
      $display("modulation_select_and_block_count test passed");
    else
      $display("modulation_select_and_block_count test failed");
    $finish;
  end

endmodule

### modulation_select_and_block_count.f
sv/msbc_pkg.sv
sv/modulation_select_and_block_count.sv
test/tb_top.sv
